// ===== rtl/fjb_pkg.sv =====
package fjb_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int SLOTS_W    = 6;
    localparam int LEN_W      = 19;
    localparam int CODEC_W    = 2;
    localparam int WORD_W     = 32;
    localparam int LAT_W      = 16;
    localparam int IDX_W      = 5;
    localparam int HELD_W     = 6;

    localparam int SLOTS_RESET  = 30;
    localparam int LIMIT_RESET  = 262144;
    localparam int TARGET_RESET = 100;
    localparam int STALE_RESET  = 500;

    localparam int MJPEG_LATENCY = 20;
    localparam logic [CODEC_W-1:0] CODEC_MJPEG = 2'd0;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_PROCESS = 2'd1,
        ACT_FLUSH   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_STORED      = 3'd0,
        KIND_OVERWRITE   = 3'd1,
        KIND_DROP_NOKEY  = 3'd2,
        KIND_REJECTED    = 3'd3,
        KIND_RELEASED    = 3'd4,
        KIND_DROP_STALE  = 3'd5,
        KIND_PROC_DONE   = 3'd6,
        KIND_FLUSHED     = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        REG_SLOTS      = 2'd0,
        REG_SIZE_LIMIT = 2'd1,
        REG_TARGET     = 2'd2,
        REG_STALE      = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_WALK_RD,
        ST_WALK_AGE,
        ST_WALK_LAT,
        ST_WALK_STALE,
        ST_DONE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [SLOTS_W-1:0] slots_in_use;
        logic [LEN_W-1:0]   frame_size_limit;
        logic [LAT_W-1:0]   latency_target;
        logic [LAT_W-1:0]   stale_limit;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
    } unit_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] diff;
        logic              borrow;
    } unit_out_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [CODEC_W-1:0] codec;
        logic [WORD_W-1:0]  info;
        logic [WORD_W-1:0]  arrival;
    } slot_data_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   slot;
        logic [LEN_W-1:0]   len;
        logic [CODEC_W-1:0] codec;
        logic [WORD_W-1:0]  info;
        logic [WORD_W-1:0]  age;
        logic [HELD_W-1:0]  held;
        logic               kwait;
        logic               last;
    } result_t;

endpackage

// ===== rtl/fjb_ram.sv =====
module fjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fjb_cfg.sv =====
module fjb_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fjb_pkg::ADDR_W-1:0] paddr,
    input  logic [fjb_pkg::DATA_W-1:0] pwdata,
    output logic [fjb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output fjb_pkg::cfg_t              cfg,
    output logic                       ring_clear
);

    logic [fjb_pkg::SLOTS_W-1:0] slots_reg;
    logic [fjb_pkg::LEN_W-1:0]   limit_reg;
    logic [fjb_pkg::LAT_W-1:0]   target_reg;
    logic [fjb_pkg::LAT_W-1:0]   stale_reg;
    logic                        wr;
    fjb_pkg::reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = fjb_pkg::reg_idx_t'(paddr[3:2]);

    assign ring_clear = wr && (idx == fjb_pkg::REG_SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg  <= fjb_pkg::SLOTS_W'(fjb_pkg::SLOTS_RESET);
            limit_reg  <= fjb_pkg::LEN_W'(fjb_pkg::LIMIT_RESET);
            target_reg <= fjb_pkg::LAT_W'(fjb_pkg::TARGET_RESET);
            stale_reg  <= fjb_pkg::LAT_W'(fjb_pkg::STALE_RESET);
        end
        else if (wr)
        begin
            case (idx)
                fjb_pkg::REG_SLOTS:      slots_reg  <= pwdata[fjb_pkg::SLOTS_W-1:0];
                fjb_pkg::REG_SIZE_LIMIT: limit_reg  <= pwdata[fjb_pkg::LEN_W-1:0];
                fjb_pkg::REG_TARGET:     target_reg <= pwdata[fjb_pkg::LAT_W-1:0];
                fjb_pkg::REG_STALE:      stale_reg  <= pwdata[fjb_pkg::LAT_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            fjb_pkg::REG_SLOTS:      prdata = fjb_pkg::DATA_W'(slots_reg);
            fjb_pkg::REG_SIZE_LIMIT: prdata = fjb_pkg::DATA_W'(limit_reg);
            fjb_pkg::REG_TARGET:     prdata = fjb_pkg::DATA_W'(target_reg);
            fjb_pkg::REG_STALE:      prdata = fjb_pkg::DATA_W'(stale_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.slots_in_use     = slots_reg;
    assign cfg.frame_size_limit = limit_reg;
    assign cfg.latency_target   = target_reg;
    assign cfg.stale_limit      = stale_reg;

endmodule

// ===== rtl/fjb_sub_unit.sv =====
module fjb_sub_unit (
    input  fjb_pkg::unit_in_t  op,
    output fjb_pkg::unit_out_t res
);

    logic [fjb_pkg::WORD_W:0] wide;

    // borrow set when op_a < op_b
    assign wide       = {1'b0, op.op_a} - {1'b0, op.op_b};
    assign res.diff   = wide[fjb_pkg::WORD_W-1:0];
    assign res.borrow = wide[fjb_pkg::WORD_W];

endmodule

// ===== rtl/frame_jitter_buffer_unit.sv =====
// Jitter buffer controller for video frame metadata held in a ring of slots. One item is
// taken at a time and in_stall stays high until its last result is in the output register.
// A push, a flush or an unused action loads its single result from its own state (PUSH,
// FLUSH, or DONE for an unused action) and then returns to idle for the next item.
// A process item walks the ring from the oldest frame: each frame visited passes through a
// slot memory read, then age subtract, latency compare and stale compare on one shared
// 32-bit subtractor. A process item releases or drops frames until it empties the ring
// or stops at a frame that is not ready yet, and then emits a process-done result.
// Every emitted result is held in an output register while out_stall is high and the
// sequencer waits for it. Writing slots_in_use empties the ring at once; there is no
// clearing pass after reset.
module frame_jitter_buffer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fjb_pkg::ADDR_W-1:0]  paddr,
    input  logic [fjb_pkg::DATA_W-1:0]  pwdata,
    output logic [fjb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  action,
    input  logic [fjb_pkg::WORD_W-1:0]  now_ms,
    input  logic [fjb_pkg::LEN_W-1:0]   frame_len,
    input  logic                        key_frame,
    input  logic [fjb_pkg::CODEC_W-1:0] codec_kind,
    input  logic [fjb_pkg::WORD_W-1:0]  info_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  kind,
    output logic [fjb_pkg::IDX_W-1:0]   slot_index,
    output logic [fjb_pkg::LEN_W-1:0]   out_len,
    output logic [fjb_pkg::CODEC_W-1:0] out_codec,
    output logic [fjb_pkg::WORD_W-1:0]  out_info,
    output logic [fjb_pkg::WORD_W-1:0]  age_ms,
    output logic [fjb_pkg::HELD_W-1:0]  frame_count,
    output logic                        awaiting_keyframe,
    output logic                        last
);

    fjb_pkg::cfg_t       cfg;
    logic                ring_clear;

    fjb_pkg::state_t     state_reg, state_next;
    logic [fjb_pkg::SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [fjb_pkg::SLOT_W-1:0]     wpos_reg, wpos_next;
    logic [fjb_pkg::SLOT_W-1:0]     rpos_reg, rpos_next;
    logic [fjb_pkg::CNT_W-1:0]      held_reg, held_next;
    logic                kwait_reg, kwait_next;
    logic                out_valid_reg, out_valid_next;
    fjb_pkg::result_t    res_reg, res_new;

    logic [fjb_pkg::WORD_W-1:0]  now_reg;
    logic [fjb_pkg::LEN_W-1:0]   len_reg;
    logic                        key_reg;
    logic [fjb_pkg::CODEC_W-1:0] codec_reg;
    logic [fjb_pkg::WORD_W-1:0]  info_reg;
    logic [fjb_pkg::WORD_W-1:0]  age_reg, age_next;
    logic                        rel_reg, rel_next;

    logic                in_accept;
    logic                out_free;
    logic                emit;
    logic [fjb_pkg::CNT_W-1:0] ring_n;
    logic [fjb_pkg::WORD_W-1:0] lat32;

    fjb_pkg::unit_in_t   unit_op;
    fjb_pkg::unit_out_t  unit_res;

    logic                ram_we;
    logic                ram_re;
    fjb_pkg::slot_data_t ram_wdata;
    logic [$bits(fjb_pkg::slot_data_t)-1:0] ram_rdata;
    fjb_pkg::slot_data_t rd;

    function automatic logic [fjb_pkg::SLOT_W-1:0] next_pos(
        input logic [fjb_pkg::SLOT_W-1:0] p,
        input logic [fjb_pkg::CNT_W-1:0]  size
    );
        logic [fjb_pkg::CNT_W-1:0] inc;
        inc = fjb_pkg::CNT_W'(p) + fjb_pkg::CNT_W'(1);
        return (inc == size) ? '0 : fjb_pkg::SLOT_W'(inc);
    endfunction

    fjb_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .ring_clear (ring_clear)
    );

    fjb_sub_unit u_sub (
        .op  (unit_op),
        .res (unit_res)
    );

    fjb_ram #(
        .WIDTH ($bits(fjb_pkg::slot_data_t)),
        .DEPTH (fjb_pkg::SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rpos_reg),
        .rdata (ram_rdata)
    );

    assign rd        = fjb_pkg::slot_data_t'(ram_rdata);
    assign in_stall  = (state_reg != fjb_pkg::ST_IDLE);
    assign in_accept = in_valid && (state_reg == fjb_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // ring size clamped to 1..SLOT_COUNT
    always_comb
    begin
        if (cfg.slots_in_use == '0)
        begin
            ring_n = fjb_pkg::CNT_W'(1);
        end
        else if (cfg.slots_in_use > fjb_pkg::SLOTS_W'(fjb_pkg::SLOT_COUNT))
        begin
            ring_n = fjb_pkg::CNT_W'(fjb_pkg::SLOT_COUNT);
        end
        else
        begin
            ring_n = fjb_pkg::CNT_W'(cfg.slots_in_use);
        end
    end

    assign lat32 = (rd.codec == fjb_pkg::CODEC_MJPEG) ?
                   fjb_pkg::WORD_W'(fjb_pkg::MJPEG_LATENCY) :
                   fjb_pkg::WORD_W'(cfg.latency_target);

    // operand select for the shared subtractor
    always_comb
    begin
        case (state_reg)
            fjb_pkg::ST_WALK_AGE:
            begin
                unit_op.op_a = now_reg;
                unit_op.op_b = rd.arrival;
            end
            fjb_pkg::ST_WALK_LAT:
            begin
                unit_op.op_a = age_reg;
                unit_op.op_b = lat32;
            end
            fjb_pkg::ST_WALK_STALE:
            begin
                unit_op.op_a = fjb_pkg::WORD_W'(cfg.stale_limit);
                unit_op.op_b = age_reg;
            end
            default:
            begin
                unit_op.op_a = fjb_pkg::WORD_W'(cfg.frame_size_limit);
                unit_op.op_b = fjb_pkg::WORD_W'(len_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        wpos_next  = wpos_reg;
        rpos_next  = rpos_reg;
        held_next  = held_reg;
        kwait_next = kwait_reg;
        age_next   = age_reg;
        rel_next   = rel_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        emit       = 1'b0;
        res_new    = '0;

        ram_wdata.len     = len_reg;
        ram_wdata.codec   = codec_reg;
        ram_wdata.info    = info_reg;
        ram_wdata.arrival = now_reg;

        case (state_reg)
            fjb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        fjb_pkg::ACT_PUSH:    state_next = fjb_pkg::ST_PUSH;
                        fjb_pkg::ACT_PROCESS: state_next = fjb_pkg::ST_WALK_RD;
                        fjb_pkg::ACT_FLUSH:   state_next = fjb_pkg::ST_FLUSH;
                        default:              state_next = fjb_pkg::ST_DONE;
                    endcase
                end
            end
            fjb_pkg::ST_PUSH:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    state_next    = fjb_pkg::ST_IDLE;
                    res_new.len   = len_reg;
                    res_new.codec = codec_reg;
                    res_new.info  = info_reg;
                    res_new.last  = 1'b1;
                    if ((len_reg == '0) || unit_res.borrow)
                    begin
                        res_new.kind = fjb_pkg::KIND_REJECTED;
                    end
                    else if (kwait_reg && !key_reg)
                    begin
                        res_new.kind = fjb_pkg::KIND_DROP_NOKEY;
                    end
                    else
                    begin
                        kwait_next           = 1'b0;
                        ram_we               = 1'b1;
                        valid_next[wpos_reg] = 1'b1;
                        wpos_next            = next_pos(wpos_reg, ring_n);
                        res_new.slot         = fjb_pkg::IDX_W'(wpos_reg);
                        if (valid_reg[wpos_reg])
                        begin
                            res_new.kind = fjb_pkg::KIND_OVERWRITE;
                            rpos_next    = next_pos(rpos_reg, ring_n);
                        end
                        else
                        begin
                            res_new.kind = fjb_pkg::KIND_STORED;
                            if (held_reg < ring_n)
                            begin
                                held_next = held_reg + fjb_pkg::CNT_W'(1);
                            end
                        end
                    end
                    res_new.held  = fjb_pkg::HELD_W'(held_next);
                    res_new.kwait = kwait_next;
                end
            end
            fjb_pkg::ST_WALK_RD:
            begin
                if (held_reg == '0)
                begin
                    state_next = fjb_pkg::ST_DONE;
                end
                else if (!valid_reg[rpos_reg])
                begin
                    rpos_next = next_pos(rpos_reg, ring_n);
                    held_next = held_reg - fjb_pkg::CNT_W'(1);
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = fjb_pkg::ST_WALK_AGE;
                end
            end
            fjb_pkg::ST_WALK_AGE:
            begin
                age_next   = unit_res.diff;
                state_next = fjb_pkg::ST_WALK_LAT;
            end
            fjb_pkg::ST_WALK_LAT:
            begin
                rel_next   = !unit_res.borrow;
                state_next = fjb_pkg::ST_WALK_STALE;
            end
            fjb_pkg::ST_WALK_STALE:
            begin
                if (rel_reg || unit_res.borrow)
                begin
                    if (out_free)
                    begin
                        emit                 = 1'b1;
                        valid_next[rpos_reg] = 1'b0;
                        rpos_next            = next_pos(rpos_reg, ring_n);
                        held_next            = held_reg - fjb_pkg::CNT_W'(1);
                        state_next           = fjb_pkg::ST_WALK_RD;
                        res_new.kind         = rel_reg ? fjb_pkg::KIND_RELEASED :
                                                         fjb_pkg::KIND_DROP_STALE;
                        res_new.slot         = fjb_pkg::IDX_W'(rpos_reg);
                        res_new.len          = rd.len;
                        res_new.codec        = rd.codec;
                        res_new.info         = rd.info;
                        res_new.age          = age_reg;
                        res_new.held         = fjb_pkg::HELD_W'(held_next);
                        res_new.kwait        = kwait_reg;
                    end
                end
                else
                begin
                    state_next = fjb_pkg::ST_DONE;
                end
            end
            fjb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    state_next    = fjb_pkg::ST_IDLE;
                    res_new.kind  = fjb_pkg::KIND_PROC_DONE;
                    res_new.held  = fjb_pkg::HELD_W'(held_reg);
                    res_new.kwait = kwait_reg;
                    res_new.last  = 1'b1;
                end
            end
            fjb_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    state_next    = fjb_pkg::ST_IDLE;
                    valid_next    = '0;
                    wpos_next     = '0;
                    rpos_next     = '0;
                    held_next     = '0;
                    kwait_next    = 1'b1;
                    res_new.kind  = fjb_pkg::KIND_FLUSHED;
                    res_new.kwait = 1'b1;
                    res_new.last  = 1'b1;
                end
            end
            default:
            begin
                state_next = fjb_pkg::ST_IDLE;
            end
        endcase

        // ring size rewritten: empty the ring, keyframe wait kept
        if (ring_clear)
        begin
            valid_next = '0;
            wpos_next  = '0;
            rpos_next  = '0;
            held_next  = '0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fjb_pkg::ST_IDLE;
            valid_reg     <= '0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            held_reg      <= '0;
            kwait_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            held_reg      <= held_next;
            kwait_reg     <= kwait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg   <= now_ms;
            len_reg   <= frame_len;
            key_reg   <= key_frame;
            codec_reg <= codec_kind;
            info_reg  <= info_word;
        end
        age_reg <= age_next;
        rel_reg <= rel_next;
        if (emit)
        begin
            res_reg <= res_new;
        end
    end

    assign out_valid         = out_valid_reg;
    assign kind              = res_reg.kind;
    assign slot_index        = res_reg.slot;
    assign out_len           = res_reg.len;
    assign out_codec         = res_reg.codec;
    assign out_info          = res_reg.info;
    assign age_ms            = res_reg.age;
    assign frame_count       = res_reg.held;
    assign awaiting_keyframe = res_reg.kwait;
    assign last              = res_reg.last;

endmodule
